FILE: hw/rtl/http_header_field_extractor_macros.svh
// assertion macros for the header field extractor checker
// needs a clk and an active-low arst_n in the scope where they are used
`ifndef HTTP_HEADER_FIELD_EXTRACTOR_MACROS_SVH
`define HTTP_HEADER_FIELD_EXTRACTOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HHFE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hhfe check failed");

// antecedent implies consequent in the next cycle
`define HHFE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hhfe check failed");

`endif

FILE: hw/rtl/hhfe_pkg.sv
// shared types, constants and helpers for the header field extractor
// used by the front, queue, drain and top level; no dependencies
`default_nettype none

package hhfe_pkg;

	localparam int NAME_MAX      = 16;
	localparam int VALUE_MAX_DEF = 64;
	localparam int VALUE_MAX_HI  = 64;
	localparam int RUN_LEN_W     = $clog2(VALUE_MAX_HI + 1);
	localparam int COL_W         = 5;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 64;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;

	localparam logic [1:0] PH_MATCH   = 2'd0;
	localparam logic [1:0] PH_SKIP    = 2'd1;
	localparam logic [1:0] PH_COLLECT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NAME_LEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NAME_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NAME_HIGH = 2'd2;

	// one pending result run
	typedef struct packed {
		logic                 mem_run;
		logic [7:0]           byte_val;
		logic                 found;
		logic                 trunc;
		logic                 bank;
		logic [RUN_LEN_W-1:0] len;
	} desc_t;

	// value bank handed back by the drain side
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_rel_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[8'h41:8'h5A]}) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hhfe_queue.sv
// short descriptor queue between the byte front and the result drain
// depends on hhfe_pkg for the descriptor type and depth
`default_nettype none

module hhfe_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  hhfe_pkg::desc_t     push_desc,
	input  wire                 pop,
	output hhfe_pkg::desc_t     head,
	output logic                empty,
	output logic                full
);

	localparam int DEPTH = hhfe_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW    = $clog2(DEPTH + 1);

	hhfe_pkg::desc_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [FW-1:0] fill_q;

	assign head  = entries_q[rd_ptr_q];
	assign empty = (fill_q == '0);
	assign full  = (fill_q == FW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/hhfe_front.sv
// byte front: name registers, line splitting, name match and value capture
// depends on hhfe_pkg; writes value bytes into the drain side's store
`default_nettype none

module hhfe_front #(
	parameter int VALUE_MAX = hhfe_pkg::VALUE_MAX_DEF,
	localparam int CW = $clog2(VALUE_MAX + 1),
	localparam int IW = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_write,
	input  wire [hhfe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [hhfe_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire [7:0]                        header_byte,
	input  wire                              block_end,
	output logic                             push,
	output hhfe_pkg::desc_t                  push_desc,
	input  wire                              q_full,
	input  hhfe_pkg::bank_rel_t              rel,
	output logic                             wr_en,
	output logic [IW:0]                      wr_addr,
	output logic [7:0]                       wr_data
);

	localparam int COL_W = hhfe_pkg::COL_W;

	logic [COL_W-1:0] name_len_q;
	logic [63:0]      name_lo_q;
	logic [63:0]      name_hi_q;

	logic [COL_W-1:0] column_q, column_n;
	logic             match_q, match_n;
	logic [1:0]       phase_q, phase_n;
	logic [CW-1:0]    count_q, count_n;
	logic [CW-1:0]    keep_q, keep_n;
	logic             over_q, over_n;
	logic             prior_cr_q, prior_cr_n;
	logic             drop_cr_q, drop_cr_n;
	logic             found_q, found_n;
	logic             has_bytes_q, has_bytes_n;
	logic             wbank_q, wbank_n;
	logic [1:0]       busy_q;
	logic [1:0]       busy_set;
	logic [1:0]       busy_clr;

	logic [COL_W-1:0] eff_len;
	logic [127:0]     name_all;
	logic [7:0]       name_b;
	logic             fire;
	logic             push_c;
	logic             wr_c;
	logic             name_ok;
	logic [1:0]       ph;

	assign eff_len  = (name_len_q > COL_W'(hhfe_pkg::NAME_MAX)) ?
		COL_W'(hhfe_pkg::NAME_MAX) : name_len_q;
	assign name_all = {name_hi_q, name_lo_q};
	assign name_b   = name_all[{column_q[3:0], 3'b000} +: 8];
	assign in_ready = !q_full && !busy_q[wbank_q];
	assign fire     = in_valid && in_ready;
	assign push     = fire && push_c;
	assign wr_en    = fire && wr_c;
	assign wr_addr  = {wbank_q, count_q[IW-1:0]};
	assign wr_data  = header_byte;

	always_comb begin
		column_n    = column_q;
		match_n     = match_q;
		phase_n     = phase_q;
		count_n     = count_q;
		keep_n      = keep_q;
		over_n      = over_q;
		prior_cr_n  = prior_cr_q;
		drop_cr_n   = drop_cr_q;
		found_n     = found_q;
		has_bytes_n = has_bytes_q;
		wbank_n     = wbank_q;
		busy_set    = 2'b00;
		push_c      = 1'b0;
		push_desc   = '0;
		wr_c        = 1'b0;
		name_ok     = 1'b0;
		ph          = phase_q;

		if (!found_q) begin
			if (drop_cr_q && header_byte == hhfe_pkg::CH_CR) begin
				drop_cr_n = 1'b0;
			end else begin
				drop_cr_n = 1'b0;
				if (header_byte == hhfe_pkg::CH_LF) begin
					// line only counts when its lf is not the last byte of the block
					if (!block_end && match_q &&
						!(phase_q == hhfe_pkg::PH_MATCH && column_q < eff_len)) begin
						push_c             = 1'b1;
						found_n            = 1'b1;
						push_desc.found    = 1'b1;
						push_desc.bank     = wbank_q;
						push_desc.trunc    = over_q;
						if (phase_q != hhfe_pkg::PH_COLLECT) begin
							push_desc.trunc    = 1'b0;
							push_desc.byte_val = prior_cr_q ? 8'h00 : hhfe_pkg::CH_LF;
						end else if (keep_q == '0) begin
							// value was only cr bytes, first one stands for it
							push_desc.byte_val = hhfe_pkg::CH_CR;
						end else begin
							push_desc.mem_run  = 1'b1;
							push_desc.len      = hhfe_pkg::RUN_LEN_W'(keep_q);
							busy_set[wbank_q]  = 1'b1;
							wbank_n            = !wbank_q;
						end
					end
					drop_cr_n   = has_bytes_q && !prior_cr_q;
					column_n    = '0;
					match_n     = 1'b1;
					phase_n     = hhfe_pkg::PH_MATCH;
					count_n     = '0;
					keep_n      = '0;
					over_n      = 1'b0;
					prior_cr_n  = 1'b0;
					has_bytes_n = 1'b0;
				end else begin
					has_bytes_n = 1'b1;
					prior_cr_n  = (header_byte == hhfe_pkg::CH_CR);
					if (phase_q == hhfe_pkg::PH_MATCH && column_q < eff_len) begin
						name_ok  = match_q && (hhfe_pkg::fold_case(header_byte) ==
							hhfe_pkg::fold_case(name_b));
						match_n  = name_ok;
						column_n = column_q + COL_W'(1);
						if ((column_q + COL_W'(1)) >= eff_len && name_ok) begin
							phase_n = hhfe_pkg::PH_SKIP;
						end
					end else begin
						ph = (phase_q == hhfe_pkg::PH_MATCH) ? hhfe_pkg::PH_SKIP : phase_q;
						if (match_q && ph == hhfe_pkg::PH_SKIP &&
							header_byte != hhfe_pkg::CH_SP) begin
							ph = hhfe_pkg::PH_COLLECT;
						end
						if (match_q && ph == hhfe_pkg::PH_COLLECT) begin
							if (count_q < CW'(VALUE_MAX)) begin
								wr_c    = 1'b1;
								count_n = count_q + CW'(1);
								if (header_byte != hhfe_pkg::CH_CR) begin
									keep_n = count_q + CW'(1);
								end
							end else if (header_byte != hhfe_pkg::CH_CR) begin
								over_n = 1'b1;
								keep_n = CW'(VALUE_MAX);
							end
						end
						phase_n = ph;
					end
				end
			end
		end

		if (block_end) begin
			if (!found_q) begin
				push_c    = 1'b1;
				push_desc = '0;
				busy_set  = 2'b00;
				wbank_n   = wbank_q;
			end
			column_n    = '0;
			match_n     = 1'b1;
			phase_n     = hhfe_pkg::PH_MATCH;
			count_n     = '0;
			keep_n      = '0;
			over_n      = 1'b0;
			prior_cr_n  = 1'b0;
			has_bytes_n = 1'b0;
			drop_cr_n   = 1'b0;
			found_n     = 1'b0;
		end
	end

	always_comb begin
		busy_clr = 2'b00;
		if (rel.valid) begin
			busy_clr[rel.bank] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_len_q <= COL_W'(1);
			name_lo_q  <= '0;
			name_hi_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				hhfe_pkg::REG_NAME_LEN:  name_len_q <= cfg_data[COL_W-1:0];
				hhfe_pkg::REG_NAME_LOW:  name_lo_q  <= cfg_data;
				hhfe_pkg::REG_NAME_HIGH: name_hi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			match_q     <= 1'b1;
			phase_q     <= hhfe_pkg::PH_MATCH;
			count_q     <= '0;
			keep_q      <= '0;
			over_q      <= 1'b0;
			prior_cr_q  <= 1'b0;
			drop_cr_q   <= 1'b0;
			found_q     <= 1'b0;
			has_bytes_q <= 1'b0;
			wbank_q     <= 1'b0;
			busy_q      <= 2'b00;
		end else begin
			if (fire) begin
				column_q    <= column_n;
				match_q     <= match_n;
				phase_q     <= phase_n;
				count_q     <= count_n;
				keep_q      <= keep_n;
				over_q      <= over_n;
				prior_cr_q  <= prior_cr_n;
				drop_cr_q   <= drop_cr_n;
				found_q     <= found_n;
				has_bytes_q <= has_bytes_n;
				wbank_q     <= wbank_n;
			end
			// a bank stays held from its run's push until its last byte is read
			busy_q <= (busy_q & ~busy_clr) | (fire ? busy_set : 2'b00);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/hhfe_back.sv
// result drain: two-bank value store and registered output stage
// depends on hhfe_pkg; takes run descriptors from hhfe_queue
`default_nettype none

module hhfe_back #(
	parameter int VALUE_MAX = hhfe_pkg::VALUE_MAX_DEF,
	localparam int CW = $clog2(VALUE_MAX + 1),
	localparam int IW = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  wr_en,
	input  wire [IW:0]           wr_addr,
	input  wire [7:0]            wr_data,
	input  hhfe_pkg::desc_t      head,
	input  wire                  q_empty,
	output logic                 pop,
	output hhfe_pkg::bank_rel_t  rel,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [7:0]           value_byte,
	output logic                 found,
	output logic                 run_end,
	output logic                 truncated
);

	localparam int DEPTH = 2 << IW;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic [CW-1:0] idx_q;
	logic          out_valid_q;
	logic          memsel_q;
	logic [7:0]    byte_q;
	logic          found_q;
	logic          run_end_q;
	logic          trunc_q;

	logic issue;
	logic last;

	assign issue = !q_empty && (!out_valid_q || out_ready);
	assign last  = !head.mem_run || (CW'(idx_q + CW'(1)) == head.len[CW-1:0]);
	assign pop   = issue && last;

	assign rel.valid = issue && head.mem_run && last;
	assign rel.bank  = head.bank;

	assign out_valid  = out_valid_q;
	assign value_byte = memsel_q ? rdata_q : byte_q;
	assign found      = found_q;
	assign run_end    = run_end_q;
	assign truncated  = trunc_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue && head.mem_run) begin
			rdata_q <= mem[{head.bank, idx_q[IW-1:0]}];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			memsel_q  <= head.mem_run;
			byte_q    <= head.byte_val;
			found_q   <= head.found;
			run_end_q <= last;
			trunc_q   <= head.trunc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (issue && head.mem_run) begin
				idx_q <= last ? '0 : idx_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/http_header_field_extractor.sv
// header bytes are taken one per cycle while in_ready is high; an lf pushes
// its line's value run, whose results leave one per cycle while out_ready is
// high; input stalls only while the two-run queue is full or both banks hold
// undrained runs; the store has two value banks of at least VALUE_MAX bytes
// arst_n clears all control state and sets the name length to one
// top level: front, descriptor queue and drain; depends on hhfe_pkg
`default_nettype none

module http_header_field_extractor #(
	parameter int VALUE_MAX = hhfe_pkg::VALUE_MAX_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_write,
	input  wire [hhfe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [hhfe_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire [7:0]                       header_byte,
	input  wire                             block_end,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [7:0]                      value_byte,
	output logic                            found,
	output logic                            run_end,
	output logic                            truncated
);

	localparam int IW = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;

	logic                push;
	hhfe_pkg::desc_t     push_desc;
	hhfe_pkg::desc_t     head;
	logic                q_empty;
	logic                q_full;
	logic                pop;
	hhfe_pkg::bank_rel_t rel;
	logic                wr_en;
	logic [IW:0]         wr_addr;
	logic [7:0]          wr_data;

	hhfe_front #(.VALUE_MAX(VALUE_MAX)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.header_byte (header_byte),
		.block_end   (block_end),
		.push        (push),
		.push_desc   (push_desc),
		.q_full      (q_full),
		.rel         (rel),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data)
	);

	hhfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	hhfe_back #(.VALUE_MAX(VALUE_MAX)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.rel        (rel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value_byte (value_byte),
		.found      (found),
		.run_end    (run_end),
		.truncated  (truncated)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/hhfe_checker.sv
// port-level checks on the result channel of the extractor
// uses http_header_field_extractor_macros.svh; bound to the top level below
`default_nettype none

`include "http_header_field_extractor_macros.svh"

module hhfe_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] value_byte,
	input wire       found,
	input wire       run_end,
	input wire       truncated
);

	// a stalled result stays offered
	`HHFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

	// not-found result is a lone zero result
	`HHFE_ASSERT_NOW(a_notfound_shape, out_valid && !found,
		run_end && value_byte == 8'h00 && !truncated)

	// only value runs have more than one result
	`HHFE_ASSERT_NOW(a_multi_is_found, out_valid && !run_end, found)

	// a value run drains without gaps and keeps its truncation flag
	`HHFE_ASSERT_NEXT(a_run_back_to_back, out_valid && out_ready && !run_end,
		out_valid && found && truncated == $past(truncated))

endmodule

bind http_header_field_extractor hhfe_checker u_hhfe_checker (.*);

`default_nettype wire
